// ===== rtl/text_console_writer_macros.svh =====
// Assertion macros used by the console checker.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Types, constants and control bundles of the text console writer.
package tcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W  = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int SCAN_W  = $clog2(CELL_COUNT + SCREEN_WIDTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR = CFG_INDEX_W'(1);

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CHAR_W-1:0] BYTE_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] BYTE_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] BYTE_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] BYTE_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] BYTE_SPACE = 8'h20;
    localparam int                TAB_STOP   = 4;

    localparam logic [CELL_W-1:0]  CELL_RESET = 16'h0F20;
    localparam logic [COLOR_W-1:0] FG_RESET   = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET   = 4'h0;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_address;
    } item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              did_scroll;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear_wr;
        logic scroll_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic need_scroll;
        logic clear_last;
        logic scroll_last;
    } stat_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
module tcw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tcw_pkg::stat_t stat,
    output tcw_pkg::cmd_t  cmd,
    output logic           busy
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (stat.is_read)
                begin
                    state_next = S_READ;
                end
                else if (stat.need_scroll)
                begin
                    state_next = S_SCROLL;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (stat.scroll_last)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/tcw_dp.sv =====
// Datapath of the text console writer: cursor, colors, screen memory, result.
module tcw_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcw_pkg::cmd_t                       cmd,
    output tcw_pkg::stat_t                      stat,
    input  tcw_pkg::item_t                      item,
    output tcw_pkg::result_t                    result,
    output logic                                done,
    input  logic                                cfg_valid,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]         cfg_data
);
    import tcw_pkg::*;

    localparam logic [COL_W:0] TAB_MASK = (COL_W+1)'(TAB_STOP - 1);

    item_t               item_reg;
    result_t             result_reg;
    logic                done_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COLOR_W-1:0]  fg_reg;
    logic [COLOR_W-1:0]  bg_reg;
    logic [SCAN_W-1:0]   scan_reg;
    logic                pipe_valid_reg;
    logic [SCAN_W-1:0]   pipe_idx_reg;

    logic [COL_W:0]      col_w;
    logic [ROW_W:0]      row_w;
    logic                put_wr;
    logic                wrap_scroll;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_next;
    logic [ADDR_W-1:0]   put_addr;
    logic [CELL_W-1:0]   put_cell;
    logic [CELL_W-1:0]   blank_cell;
    logic                is_read;
    logic                in_range;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    assign is_read    = (item_reg.op == OP_READ);
    assign in_range   = (item_reg.cell_address < ADDR_W'(CELL_COUNT));
    assign put_cell   = {bg_reg, fg_reg, item_reg.char_code};
    assign blank_cell = {bg_reg, fg_reg, BYTE_SPACE};
    assign put_addr   = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_reg));

    always_comb
    begin
        col_w  = {1'b0, col_reg};
        row_w  = {1'b0, row_reg};
        put_wr = 1'b0;
        if (item_reg.char_code == BYTE_BS)
        begin
            if (col_reg != '0)
            begin
                col_w = col_w - (COL_W+1)'(1);
            end
        end
        else if (item_reg.char_code == BYTE_NL)
        begin
            col_w = '0;
            row_w = row_w + (ROW_W+1)'(1);
        end
        else if (item_reg.char_code == BYTE_CR)
        begin
            col_w = '0;
        end
        else if (item_reg.char_code == BYTE_TAB)
        begin
            col_w = (col_w | TAB_MASK) + (COL_W+1)'(1);
        end
        else if (item_reg.char_code >= BYTE_SPACE)
        begin
            put_wr = 1'b1;
            col_w  = col_w + (COL_W+1)'(1);
        end
        if (col_w >= (COL_W+1)'(SCREEN_WIDTH))
        begin
            col_w = '0;
            row_w = row_w + (ROW_W+1)'(1);
        end
        wrap_scroll = (row_w >= (ROW_W+1)'(SCREEN_HEIGHT));
        row_next    = wrap_scroll ? ROW_W'(SCREEN_HEIGHT - 1) : row_w[ROW_W-1:0];
        col_next    = wrap_scroll ? '0 : col_w[COL_W-1:0];
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (cmd.clear_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = scan_reg[ADDR_W-1:0];
            ram_wdata = CELL_RESET;
        end
        else if (cmd.scroll_step && pipe_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(pipe_idx_reg - SCAN_W'(SCREEN_WIDTH));
            ram_wdata = (pipe_idx_reg < SCAN_W'(CELL_COUNT)) ? ram_rdata : blank_cell;
        end
        else if (cmd.exec && !is_read && put_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = put_addr;
            ram_wdata = put_cell;
        end
    end

    always_comb
    begin
        priority if (cmd.scroll_step && (scan_reg < SCAN_W'(CELL_COUNT)))
        begin
            ram_raddr = scan_reg[ADDR_W-1:0];
        end
        else if (in_range)
        begin
            ram_raddr = item_reg.cell_address;
        end
        else
        begin
            ram_raddr = '0;
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            fg_reg         <= FG_RESET;
            bg_reg         <= BG_RESET;
            scan_reg       <= '0;
            pipe_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cfg_valid)
            begin
                if (cfg_index == REG_FG_COLOR)
                begin
                    fg_reg <= cfg_data;
                end
                else if (cfg_index == REG_BG_COLOR)
                begin
                    bg_reg <= cfg_data;
                end
            end
            if (cmd.exec && !is_read)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (cmd.clear_wr)
            begin
                scan_reg <= scan_reg + SCAN_W'(1);
            end
            else if (cmd.exec)
            begin
                scan_reg       <= SCAN_W'(SCREEN_WIDTH);
                pipe_valid_reg <= 1'b0;
            end
            else if (cmd.scroll_step)
            begin
                scan_reg       <= scan_reg + SCAN_W'(1);
                pipe_valid_reg <= !stat.scroll_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.scroll_step)
        begin
            pipe_idx_reg <= scan_reg;
        end
        if (cmd.emit)
        begin
            result_reg.cell_value    <= (is_read && in_range) ? ram_rdata : '0;
            result_reg.cursor_row    <= cmd.exec ? row_next : row_reg;
            result_reg.cursor_column <= cmd.exec ? col_next : col_reg;
            result_reg.did_scroll    <= cmd.scroll_step;
        end
    end

    assign stat.is_read     = is_read;
    assign stat.need_scroll = !is_read && wrap_scroll;
    assign stat.clear_last  = (scan_reg == SCAN_W'(CELL_COUNT - 1));
    assign stat.scroll_last = (scan_reg == SCAN_W'(CELL_COUNT + SCREEN_WIDTH));

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: controller plus datapath.
//
//  channel   handshake               payload
//  request   start / busy            item   (op, char_code, cell_address)
//  result    done (one-cycle strobe) result (cell_value, cursor, did_scroll)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A put request runs from acceptance through the execute state to the registered
// done strobe; a read also passes the read state. A put that scrolls adds one sweep
// of the screen RAM (separate read and write ports) that copies each line up and
// fills the bottom line. After reset a clearing pass writes every cell; busy stays high.
// Config writes are taken in every cycle; results cannot be stalled.
module text_console_writer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  tcw_pkg::item_t                   item,
    output logic                             done,
    output tcw_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tcw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .result    (result),
        .done      (done),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
`include "text_console_writer_macros.svh"

module tcw_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  tcw_pkg::item_t                   item,
    input  logic                             done,
    input  tcw_pkg::result_t                 result,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `TCW_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a request in work")
    `TCW_ASSERT_NEXT(a_done_single, done, !done, "two results back to back")
    `TCW_ASSERT_SAME(a_cursor_range, done, (result.cursor_row < ROW_W'(SCREEN_HEIGHT)) && (result.cursor_column < COL_W'(SCREEN_WIDTH)), "cursor out of screen")
    `TCW_ASSERT_SAME(a_scroll_home, done && result.did_scroll, (result.cursor_row == ROW_W'(SCREEN_HEIGHT - 1)) && (result.cursor_column == '0), "scroll left cursor off bottom line start")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
